FILE: hdl/assert_macros.svh
// Assertion macros used by the serial flash loader result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define SFL_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfl assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define SFL_CHECK_NEXT(lbl, ante, cons) \
  `SFL_CHECK(lbl, (ante) |=> (cons))

`endif

FILE: hdl/sfl_pkg.sv
// Types, codes and helper functions shared by the serial flash loader modules.
package sfl_pkg;

  localparam int ROW_BYTES_DEF      = 16;
  localparam int ROWS_PER_ERASE_DEF = 4;

  localparam logic [7:0]  BOOT_DELAY_RST      = 8'd122;
  localparam logic [15:0] PROTECTED_LIMIT_RST = 16'h0800;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DELAY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED_LIMIT = 1'd1;

  localparam logic [2:0] ACT_MSG    = 3'd0;
  localparam logic [2:0] ACT_ERASE  = 3'd1;
  localparam logic [2:0] ACT_LATCH  = 3'd2;
  localparam logic [2:0] ACT_COMMIT = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_LAUNCH = 3'd5;

  localparam logic [1:0] MSG_READY    = 2'd0;
  localparam logic [1:0] MSG_PLAY     = 2'd1;
  localparam logic [1:0] MSG_ILLEGAL  = 2'd2;
  localparam logic [1:0] MSG_LOADSTAR = 2'd3;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } sfl_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  message_code;
    logic [15:0] flash_address;
    logic [7:0]  flash_data;
    logic [15:0] burst_length;
    logic        last;
  } sfl_out_t;

  // All results caused by one input transaction, in order.
  typedef struct packed {
    logic [2:0]                   count;
    sfl_out_t [MAX_RESULTS-1:0]   res;
  } sfl_bundle_t;

  // Character of the unlock key at a given position.
  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h4C;
      3'd1:    ch = 8'h4F;
      3'd2:    ch = 8'h41;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h0A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic sfl_out_t mk_result(input logic [2:0] act, input logic [1:0] msg,
                                         input logic [15:0] addr, input logic [7:0] data,
                                         input logic [15:0] len);
    sfl_out_t r;
    r.action        = act;
    r.message_code  = msg;
    r.flash_address = addr;
    r.flash_data    = data;
    r.burst_length  = len;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

FILE: hdl/sfl_engine.sv
// Loader state and the combinational step logic that builds each result bundle.
module sfl_engine #(
  parameter int ROW_BYTES      = sfl_pkg::ROW_BYTES_DEF,
  parameter int ROWS_PER_ERASE = sfl_pkg::ROWS_PER_ERASE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sfl_pkg::sfl_in_t    item,
  input  logic [7:0]          boot_delay_ticks,
  input  logic [15:0]         protected_limit,
  output sfl_pkg::sfl_bundle_t bundle
);
  import sfl_pkg::*;

  localparam int BirW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int RowW = (ROWS_PER_ERASE > 1) ? $clog2(ROWS_PER_ERASE) : 1;
  localparam logic [BirW-1:0] BirLast = BirW'(ROW_BYTES - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(ROWS_PER_ERASE - 1);

  // Frame tags, first byte in the top bits.
  localparam logic [31:0] TagRead = "READ";
  localparam logic [31:0] TagWrit = "WRIT";
  localparam logic [31:0] TagQuit = "QUIT";

  localparam logic [2:0] PH_KEY   = 3'd0;
  localparam logic [2:0] PH_FRAME = 3'd1;
  localparam logic [2:0] PH_WRITE = 3'd2;
  localparam logic [2:0] PH_HALT  = 3'd3;
  localparam logic [2:0] PH_GONE  = 3'd4;

  logic [2:0]      phase, phase_next;
  logic [2:0]      key_position, key_position_next;
  logic [7:0]      tick_count, tick_count_next;
  logic [2:0]      frame_position, frame_position_next;
  logic [7:0]      frame_bytes [7];
  logic [15:0]     write_address, write_address_next;
  logic [15:0]     transfer_size, transfer_size_next;
  logic [16:0]     bytes_done, bytes_done_next;
  logic [RowW-1:0] row_in_block, row_in_block_next;
  logic [BirW-1:0] byte_in_row, byte_in_row_next;

  logic [2:0]  n;
  logic [7:0]  tick_inc;
  logic [15:0] frame_addr, frame_size, row_addr_next;
  logic [31:0] frame_tag;
  logic [16:0] bytes_inc;
  logic        is_read, is_writ, is_quit;

  assign frame_addr = {frame_bytes[5], frame_bytes[4]};
  assign frame_size = {item.rx_byte, frame_bytes[6]};
  assign frame_tag  = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3]};
  assign is_read = frame_tag == TagRead;
  assign is_writ = frame_tag == TagWrit;
  assign is_quit = frame_tag == TagQuit;
  assign tick_inc  = (tick_count != 8'hFF) ? tick_count + 8'd1 : tick_count;
  assign bytes_inc = (bytes_done != 17'h1FFFF) ? bytes_done + 17'd1 : bytes_done;
  assign row_addr_next = write_address + 16'(ROW_BYTES);

  always_comb begin
    phase_next          = phase;
    key_position_next   = key_position;
    tick_count_next     = tick_count;
    frame_position_next = frame_position;
    write_address_next  = write_address;
    transfer_size_next  = transfer_size;
    bytes_done_next     = bytes_done;
    row_in_block_next   = row_in_block;
    byte_in_row_next    = byte_in_row;
    bundle              = '0;
    n                   = 3'd0;

    case (phase)
      PH_KEY: begin
        if (item.cmd) begin
          tick_count_next = tick_inc;
          if (tick_inc >= boot_delay_ticks) begin
            bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_LOADSTAR, '0, '0, '0);
            n = n + 3'd1;
            bundle.res[n[1:0]] = mk_result(ACT_LAUNCH, MSG_READY, '0, '0, '0);
            n = n + 3'd1;
            phase_next = PH_GONE;
          end
        end else if (key_position < 3'd5 && item.rx_byte == key_char(key_position)) begin
          if (key_position == 3'd4) begin
            key_position_next   = 3'd0;
            frame_position_next = 3'd0;
            phase_next          = PH_FRAME;
            bundle.res[n[1:0]]  = mk_result(ACT_MSG, MSG_PLAY, '0, '0, '0);
            n = n + 3'd1;
          end else begin
            key_position_next = key_position + 3'd1;
          end
        end else begin
          key_position_next = (item.rx_byte == key_char(3'd0)) ? 3'd1 : 3'd0;
        end
      end
      PH_FRAME: begin
        if (!item.cmd) begin
          frame_position_next = frame_position + 3'd1;
          if (frame_position == 3'd7) begin
            // Eighth byte completes the frame; it is used directly from the input.
            write_address_next = frame_addr;
            transfer_size_next = frame_size;
            if (is_read) begin
              bundle.res[n[1:0]] = mk_result(ACT_READ, MSG_READY, frame_addr, '0, frame_size);
              n = n + 3'd1;
            end else if (is_writ) begin
              if (frame_addr < protected_limit) begin
                bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_ILLEGAL, '0, '0, '0);
                n = n + 3'd1;
                phase_next = PH_HALT;
              end else if (frame_size == 16'd0) begin
                bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_READY, '0, '0, '0);
                n = n + 3'd1;
              end else begin
                bytes_done_next   = '0;
                row_in_block_next = '0;
                byte_in_row_next  = '0;
                bundle.res[n[1:0]] = mk_result(ACT_ERASE, MSG_READY, frame_addr, '0, '0);
                n = n + 3'd1;
                bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_READY, '0, '0, '0);
                n = n + 3'd1;
                phase_next = PH_WRITE;
              end
            end else if (is_quit) begin
              bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_LOADSTAR, '0, '0, '0);
              n = n + 3'd1;
              bundle.res[n[1:0]] = mk_result(ACT_LAUNCH, MSG_READY, '0, '0, '0);
              n = n + 3'd1;
              phase_next = PH_GONE;
            end
          end
        end
      end
      PH_WRITE: begin
        if (!item.cmd) begin
          bundle.res[n[1:0]] = mk_result(ACT_LATCH, MSG_READY,
                                         write_address + 16'(byte_in_row), item.rx_byte, '0);
          n = n + 3'd1;
          bytes_done_next = bytes_inc;
          if (byte_in_row == BirLast) begin
            bundle.res[n[1:0]] = mk_result(ACT_COMMIT, MSG_READY, write_address, '0, '0);
            n = n + 3'd1;
            write_address_next = row_addr_next;
            byte_in_row_next   = '0;
            if (bytes_inc >= {1'b0, transfer_size}) begin
              phase_next        = PH_FRAME;
              row_in_block_next = '0;
            end else if (row_in_block == RowLast) begin
              row_in_block_next  = '0;
              bundle.res[n[1:0]] = mk_result(ACT_ERASE, MSG_READY, row_addr_next, '0, '0);
              n = n + 3'd1;
            end else begin
              row_in_block_next = row_in_block + RowW'(1);
            end
            bundle.res[n[1:0]] = mk_result(ACT_MSG, MSG_READY, '0, '0, '0);
            n = n + 3'd1;
          end else begin
            byte_in_row_next = byte_in_row + BirW'(1);
          end
        end
      end
      default: begin
        // Halted or launched: everything is ignored until reset.
      end
    endcase

    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_KEY;
      key_position   <= '0;
      tick_count     <= '0;
      frame_position <= '0;
      write_address  <= '0;
      transfer_size  <= '0;
      bytes_done     <= '0;
      row_in_block   <= '0;
      byte_in_row    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      key_position   <= key_position_next;
      tick_count     <= tick_count_next;
      frame_position <= frame_position_next;
      write_address  <= write_address_next;
      transfer_size  <= transfer_size_next;
      bytes_done     <= bytes_done_next;
      row_in_block   <= row_in_block_next;
      byte_in_row    <= byte_in_row_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 7; i++) begin
      if (step && phase == PH_FRAME && !item.cmd && frame_position == 3'(i)) begin
        frame_bytes[i] <= item.rx_byte;
      end
    end
  end

endmodule

FILE: hdl/sfl_out_queue.sv
// One-bundle result register; hands out a result per cycle while out_ready is high.
`include "assert_macros.svh"

module sfl_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  sfl_pkg::sfl_bundle_t bundle,
  output logic                 load_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfl_pkg::sfl_out_t    out_data
);
  import sfl_pkg::*;

  sfl_out_t [MAX_RESULTS-1:0] held;
  logic [2:0] count;
  logic [1:0] idx;
  logic       busy, at_last, deliver;

  assign busy    = count != 3'd0;
  assign at_last = {1'b0, idx} == (count - 3'd1);
  assign deliver = busy && out_ready;
  assign load_ok = !busy || (out_ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= bundle.count;
      idx   <= '0;
    end else if (deliver) begin
      if (at_last) begin
        count <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle.res;
    end
  end

  always_comb begin
    out_data      = held[idx];
    out_data.last = at_last;
  end

  assign out_valid = busy;

  `SFL_CHECK(idx_in_range, busy |-> ({1'b0, idx} < count))
  `SFL_CHECK(count_bounded, count <= 3'd4)
  `SFL_CHECK_NEXT(drains_when_done, deliver && at_last && !load, !out_valid)

endmodule

FILE: hdl/serial_flash_loader_command_engine_core.sv
// Top level of the serial flash loader command engine: input register, engine, result queue.
// An accepted transaction waits in the input register, is stepped through the engine once
//   the result queue can take its bundle, and its results are then handed out by the queue.
// Throughput: one transaction per cycle while each causes at most one result and out_ready
//   is high; one with k results (at most four) keeps the queue busy until all are taken.
// Reset (rst, synchronous, active high) clears the engine and restores both register defaults.
module serial_flash_loader_command_engine_core #(
  parameter int ROW_BYTES      = sfl_pkg::ROW_BYTES_DEF,
  parameter int ROWS_PER_ERASE = sfl_pkg::ROWS_PER_ERASE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sfl_pkg::sfl_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sfl_pkg::sfl_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfl_pkg::*;

  // Configuration registers. They are to be written by the user only while the block is idle;
  // it is not enforced. Reset sets the boot delay to 122 ticks, the protected limit to 0x0800.
  logic [7:0]  boot_delay_ticks;
  logic [15:0] protected_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_delay_ticks <= BOOT_DELAY_RST;
      protected_limit  <= PROTECTED_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOOT_DELAY:      boot_delay_ticks <= cfg_data[7:0];
        CFG_PROTECTED_LIMIT: protected_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. A held transaction is stepped through the engine as soon as the
  // result queue can take its bundle; the register refills in the same cycle, so a new
  // transaction is taken every cycle while the queue keeps up.
  sfl_in_t     in_q;
  logic        in_q_valid;
  logic        process;
  logic        load_ok;
  sfl_bundle_t bundle;

  assign process  = in_q_valid && load_ok;
  assign in_ready = !in_q_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  // The engine builds the whole result bundle combinationally and updates its state on step.
  sfl_engine #(
    .ROW_BYTES      (ROW_BYTES),
    .ROWS_PER_ERASE (ROWS_PER_ERASE)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .step             (process),
    .item             (in_q),
    .boot_delay_ticks (boot_delay_ticks),
    .protected_limit  (protected_limit),
    .bundle           (bundle)
  );

  // The queue takes every stepped bundle; an empty bundle simply leaves it idle.
  sfl_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (process),
    .bundle    (bundle),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the serial flash loader command engine core.
module testbench;
  import sfl_pkg::*;

  // Geometry of the flash rows, taken from the same defaults the block is built with.
  localparam int ROW_BYTES      = ROW_BYTES_DEF;
  localparam int ROWS_PER_ERASE = ROWS_PER_ERASE_DEF;

  // Kinds of input transaction.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // The unlock key, ending in a newline, and the three frame tags.
  localparam logic [7:0]  KEY_TEXT [5] = '{"L", "O", "A", "D", 8'h0A};
  localparam logic [31:0] TAG_READ = "READ";
  localparam logic [31:0] TAG_WRIT = "WRIT";
  localparam logic [31:0] TAG_QUIT = "QUIT";

  // Received bytes driven in each random segment.
  localparam int SEGMENT_BYTES = 100;
  // An accepted transaction that causes nothing may still sit in the input register or the
  // engine, so settle this long before touching the registers.
  localparam int ENGINE_SETTLE = 4;
  localparam int DRAIN_CYCLES  = 8;
  // Cycles without any transaction before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_FRAME,
    PH_WRITE,
    PH_HALT,
    PH_GONE
  } loader_phase_e;

  // One row of the directed table. Where preset is set, the row's single flash action is
  // written out here; otherwise the predictor supplies whatever the row causes.
  typedef struct packed {
    sfl_in_t  item;
    logic     preset;
    sfl_out_t action;
  } directed_row_t;

  localparam sfl_out_t NO_ACTION = '0;

  // Directed part: the key with a tick, a plain mismatch and a mismatch on 'L' in front of it,
  // then a read burst with every address and size bit set, then a zero-size write placed
  // exactly on the reset protection limit, which must be allowed.
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    '{'{CMD_TICK, 8'hFF}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, "L"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "X"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "L"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "L"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "O"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "A"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "D"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'h0A}, 1'b1, '{ACT_MSG, MSG_PLAY, 16'h0000, 8'h00, 16'h0000, 1'b1}},
    '{'{CMD_BYTE, "R"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "E"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "A"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "D"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'hFF}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'hFF}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'hFF}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'hFF}, 1'b1, '{ACT_READ, 2'd0, 16'hFFFF, 8'h00, 16'hFFFF, 1'b1}},
    '{'{CMD_BYTE, "W"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "R"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "I"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, "T"},   1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'h00}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'h08}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'h00}, 1'b0, NO_ACTION},
    '{'{CMD_BYTE, 8'h00}, 1'b1, '{ACT_MSG, MSG_READY, 16'h0000, 8'h00, 16'h0000, 1'b1}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sfl_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sfl_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state, mirroring the engine from reset on.
  loader_phase_e engine_phase = PH_KEY;
  int            key_pos = 0;
  logic [7:0]    tick_count = '0;
  logic [2:0]    frame_pos = '0;
  logic [7:0]    frame_buf [8];
  logic [15:0]   write_addr = '0;
  logic [15:0]   write_size = '0;
  logic [16:0]   bytes_written = '0;
  int            row_in_block = 0;
  int            byte_in_row = 0;

  // Predictor copy of the two configuration registers.
  logic [7:0]  delay_ticks = BOOT_DELAY_RST;
  logic [15:0] limit_addr = PROTECTED_LIMIT_RST;

  // Flash actions still owed by the block, oldest first, and those of the latest transaction.
  sfl_out_t awaited_actions [$];
  sfl_out_t step_actions [$];

  int fail_count = 0;
  int byte_count = 0;
  int quiet_cycles = 0;
  // Percentage of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 22;
  int recv_idle_pct = 88;

  serial_flash_loader_command_engine_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_action(input logic [2:0] act, input logic [1:0] msg,
                                     input logic [15:0] addr, input logic [7:0] data,
                                     input logic [15:0] len);
    sfl_out_t a;
    a = '{act, msg, addr, data, len, 1'b0};
    step_actions.push_back(a);
  endfunction

  // Handing over to the user program announces itself first, and nothing follows it.
  function automatic void launch_user_program();
    add_action(ACT_MSG, MSG_LOADSTAR, '0, '0, '0);
    add_action(ACT_LAUNCH, '0, '0, '0, '0);
    engine_phase = PH_GONE;
  endfunction

  // Advances the predictor by one input transaction and leaves the flash actions it causes,
  // in order and with the final one marked, in step_actions.
  function automatic void compute_actions(input sfl_in_t item);
    logic [7:0]  b;
    logic [31:0] tag;
    sfl_out_t    final_action;
    step_actions.delete();
    b = item.rx_byte;
    case (engine_phase)
      PH_KEY: begin
        if (item.cmd == CMD_TICK) begin
          // The tick counter saturates; the boot delay is checked on every tick.
          if (tick_count != 8'hFF) tick_count++;
          if (tick_count >= delay_ticks) launch_user_program();
        end else if (b == KEY_TEXT[key_pos]) begin
          key_pos++;
          if (key_pos == 5) begin
            key_pos = 0;
            frame_pos = '0;
            engine_phase = PH_FRAME;
            add_action(ACT_MSG, MSG_PLAY, '0, '0, '0);
          end
        end else begin
          // A wrong byte restarts the match, but an 'L' already counts as its first byte.
          key_pos = (b == KEY_TEXT[0]) ? 1 : 0;
        end
      end
      PH_FRAME: begin
        if (item.cmd == CMD_BYTE) begin
          frame_buf[frame_pos] = b;
          frame_pos = frame_pos + 3'd1;
          if (frame_pos == 3'd0) begin
            // Address and size are little endian and are taken even for unknown tags.
            tag = {frame_buf[0], frame_buf[1], frame_buf[2], frame_buf[3]};
            write_addr = {frame_buf[5], frame_buf[4]};
            write_size = {frame_buf[7], frame_buf[6]};
            if (tag == TAG_READ) begin
              add_action(ACT_READ, '0, write_addr, '0, write_size);
            end else if (tag == TAG_WRIT) begin
              if (write_addr < limit_addr) begin
                add_action(ACT_MSG, MSG_ILLEGAL, '0, '0, '0);
                engine_phase = PH_HALT;
              end else if (write_size == 16'd0) begin
                add_action(ACT_MSG, MSG_READY, '0, '0, '0);
              end else begin
                bytes_written = '0;
                row_in_block = 0;
                byte_in_row = 0;
                add_action(ACT_ERASE, '0, write_addr, '0, '0);
                add_action(ACT_MSG, MSG_READY, '0, '0, '0);
                engine_phase = PH_WRITE;
              end
            end else if (tag == TAG_QUIT) begin
              launch_user_program();
            end
          end
        end
      end
      PH_WRITE: begin
        if (item.cmd == CMD_BYTE) begin
          add_action(ACT_LATCH, '0, write_addr + 16'(byte_in_row), b, '0);
          if (bytes_written != 17'h1FFFF) bytes_written++;
          byte_in_row++;
          if (byte_in_row == ROW_BYTES) begin
            // A full row is committed even when the size ends inside it. The row address
            // wraps within 16 bits, and a new block is erased only if more data follows.
            add_action(ACT_COMMIT, '0, write_addr, '0, '0);
            write_addr = write_addr + 16'(ROW_BYTES);
            byte_in_row = 0;
            row_in_block++;
            if (bytes_written >= {1'b0, write_size}) begin
              engine_phase = PH_FRAME;
            end else if (row_in_block == ROWS_PER_ERASE) begin
              row_in_block = 0;
              add_action(ACT_ERASE, '0, write_addr, '0, '0);
            end
            add_action(ACT_MSG, MSG_READY, '0, '0, '0);
          end
        end
      end
      default: begin
        // Halted or launched: only a reset brings the engine back.
      end
    endcase
    if (step_actions.size() != 0) begin
      final_action = step_actions.pop_back();
      final_action.last = 1'b1;
      step_actions.push_back(final_action);
    end
  endfunction

  // Offers one input transaction after a random idle gap and, once it is accepted, records
  // the flash actions it must cause.
  task automatic send_item(input sfl_in_t item, input logic preset = 1'b0,
                           input sfl_out_t preset_action = '0);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (item.cmd == CMD_BYTE) byte_count++;
    compute_actions(item);
    if (preset) begin
      awaited_actions.push_back(preset_action);
    end else begin
      foreach (step_actions[i]) awaited_actions.push_back(step_actions[i]);
    end
  endtask

  // Holds the sender back until every owed action has arrived and the engine has settled.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_actions.size() != 0) @(posedge clk);
    repeat (ENGINE_SETTLE) @(posedge clk);
  endtask

  // Writes both registers back to back on an idle block. The boot delay register takes only
  // the low byte of the write data, so the upper byte carries noise.
  task automatic set_config(input logic [7:0] delay, input logic [15:0] limit);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BOOT_DELAY;
    cfg_data <= {8'($urandom), delay};
    @(posedge clk);
    cfg_index <= CFG_PROTECTED_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_ticks = delay;
    limit_addr = limit;
  endtask

  // Sends an eight-byte command frame with the odd timer tick mixed in.
  task automatic send_frame(input logic [31:0] tag, input logic [15:0] addr,
                            input logic [15:0] size);
    logic [63:0] frame;
    frame = {tag, addr[7:0], addr[15:8], size[7:0], size[15:8]};
    for (int i = 7; i >= 0; i--) begin
      if ($urandom_range(24) == 0) send_item('{CMD_TICK, 8'($urandom)});
      send_item('{CMD_BYTE, frame[i*8 +: 8]});
    end
  endtask

  // One step of the random part. In a write it streams a data byte; otherwise it sends a
  // frame: mostly reads and allowed writes, the rest unknown tags and tags one byte off.
  task automatic drive_random_step();
    logic [31:0] tag;
    logic [15:0] addr;
    logic [15:0] size;
    int          pick;
    if (engine_phase == PH_WRITE) begin
      if ($urandom_range(19) == 0) send_item('{CMD_TICK, 8'($urandom)});
      send_item('{CMD_BYTE, 8'($urandom)});
    end else begin
      if ($urandom_range(14) == 0) wait_drained();
      pick = $urandom_range(99);
      addr = 16'($urandom);
      size = 16'($urandom);
      if (pick < 35) begin
        tag = TAG_READ;
        if ($urandom_range(9) == 0) size = '0;
      end else if (pick < 80) begin
        // Writes stay at or above the limit; a quarter of them start in the top 64 bytes so
        // that the row addresses wrap past 0xFFFF.
        tag = TAG_WRIT;
        if ($urandom_range(3) == 0)
          addr = 16'($urandom_range(16'hFFFF, (limit_addr > 16'hFFC0) ? limit_addr : 16'hFFC0));
        else
          addr = 16'($urandom_range(16'hFFFF, limit_addr));
        pick = $urandom_range(9);
        if (pick == 0) size = '0;
        else if (pick < 7) size = 16'($urandom_range(48, 1));
        else size = 16'($urandom_range(80, 49));
      end else if (pick < 90) begin
        tag = $urandom;
      end else begin
        case ($urandom_range(2))
          0:       tag = TAG_READ;
          1:       tag = TAG_WRIT;
          default: tag = TAG_QUIT;
        endcase
        tag = tag ^ (32'($urandom_range(255, 1)) << (8 * $urandom_range(3)));
      end
      send_frame(tag, addr, size);
    end
  endtask

  initial begin
    int seg_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset values of both registers.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].preset, DIRECTED_ROWS[i].action);

    // Random part in three segments: a slow receiver, then a slow sender, then no idling.
    // Each starts on a drained block with new register values, extremes included.
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          set_config(8'd255, 16'h0000);
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 22;
          set_config(8'($urandom_range(254, 2)), 16'($urandom_range(16'hFFFE, 1)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_config(8'd1, 16'hFFFF);
        end
      endcase
      seg_start = byte_count;
      while (byte_count - seg_start < SEGMENT_BYTES) drive_random_step();
    end

    // Close the run with either a quit or a write below the limit, which is everything but
    // 0xFFFF by now. Whatever follows must be ignored.
    while (engine_phase == PH_WRITE) drive_random_step();
    if ($urandom_range(1) == 1)
      send_frame(TAG_QUIT, 16'($urandom), 16'($urandom));
    else
      send_frame(TAG_WRIT, 16'($urandom_range(16'hFFFE, 0)), 16'($urandom));
    repeat (6) send_item('{1'($urandom), 8'($urandom)});

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && awaited_actions.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result transaction is compared field by field with the oldest owed action.
  always @(posedge clk) begin : check_actions
    sfl_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_actions.size() == 0) begin
        $error("unexpected result transaction: action %0d", out_data.action);
        fail_count++;
      end else begin
        want = awaited_actions.pop_front();
        if (out_data.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_data.action);
          fail_count++;
        end
        if (out_data.message_code !== want.message_code) begin
          $error("message_code: expected %0d, got %0d", want.message_code,
                 out_data.message_code);
          fail_count++;
        end
        if (out_data.flash_address !== want.flash_address) begin
          $error("flash_address: expected %h, got %h", want.flash_address,
                 out_data.flash_address);
          fail_count++;
        end
        if (out_data.flash_data !== want.flash_data) begin
          $error("flash_data: expected %h, got %h", want.flash_data, out_data.flash_data);
          fail_count++;
        end
        if (out_data.burst_length !== want.burst_length) begin
          $error("burst_length: expected %h, got %h", want.burst_length,
                 out_data.burst_length);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // A block that stops moving transactions ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: serial_flash_loader_command_engine_core.f
+incdir+hdl
hdl/sfl_pkg.sv
hdl/sfl_engine.sv
hdl/sfl_out_queue.sv
hdl/serial_flash_loader_command_engine_core.sv
test/testbench.sv
